### rtl/core/sradd_pkg.sv
`timescale 1ns / 1ps

package sradd_pkg;

    // Digit and store geometry
    localparam int DIG_W      = 6;
    localparam int MAX_DIGITS = 32;
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int SUM_W      = DIG_W + 2;

    // Radix limits and reset value
    localparam logic [DIG_W-1:0] RADIX_RESET = DIG_W'(17);
    localparam logic [DIG_W-1:0] RADIX_MIN   = DIG_W'(2);
    localparam logic [DIG_W-1:0] RADIX_MAX   = DIG_W'(36);

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIGIT = 2'd1;
    localparam logic [1:0] ERR_COUNT = 2'd2;

    typedef struct packed {
        logic [DIG_W-1:0] digit_a;
        logic [DIG_W-1:0] digit_b;
        logic             negative_a;
        logic             negative_b;
        logic             last_digit;
    } in_item_t;

    typedef struct packed {
        logic [DIG_W-1:0] result_digit;
        logic             result_negative;
        logic [1:0]       error_code;
        logic             last_result;
    } out_item_t;

    // Control of the digit ALU
    typedef struct packed {
        logic             sub;
        logic             swap;
        logic [DIG_W-1:0] radix;
    } alu_ctrl_t;

endpackage

### rtl/core/sradd_ram.sv
`timescale 1ns / 1ps

module sradd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/sradd_digit_alu.sv
`timescale 1ns / 1ps

module sradd_digit_alu (
    input  sradd_pkg::alu_ctrl_t            ctrl,
    input  logic [sradd_pkg::DIG_W-1:0]     digit_a,
    input  logic [sradd_pkg::DIG_W-1:0]     digit_b,
    input  logic                            carry_in,
    output logic [sradd_pkg::DIG_W-1:0]     digit_out,
    output logic                            carry_out,
    output logic                            bad_digit
);

    logic [sradd_pkg::DIG_W-1:0] big;
    logic [sradd_pkg::DIG_W-1:0] small_d;
    logic [sradd_pkg::SUM_W-1:0] rad;
    logic [sradd_pkg::SUM_W-1:0] sum;
    logic [sradd_pkg::SUM_W-1:0] diff;
    logic [sradd_pkg::SUM_W-1:0] res;

    // One digit position: add with carry or subtract with borrow, mod radix
    always_comb
    begin
        big     = ctrl.swap ? digit_b : digit_a;
        small_d = ctrl.swap ? digit_a : digit_b;
        rad     = sradd_pkg::SUM_W'(ctrl.radix);
        sum     = sradd_pkg::SUM_W'(digit_a) + sradd_pkg::SUM_W'(digit_b)
                  + sradd_pkg::SUM_W'(carry_in);
        diff    = sradd_pkg::SUM_W'(big) - sradd_pkg::SUM_W'(small_d)
                  - sradd_pkg::SUM_W'(carry_in);
        if (ctrl.sub)
        begin
            // negative difference wraps by one radix
            if (diff[sradd_pkg::SUM_W-1])
            begin
                res       = diff + rad;
                carry_out = 1'b1;
            end
            else
            begin
                res       = diff;
                carry_out = 1'b0;
            end
        end
        else
        begin
            // valid digits keep the sum below twice the radix
            if (sum >= rad)
            begin
                res       = sum - rad;
                carry_out = 1'b1;
            end
            else
            begin
                res       = sum;
                carry_out = 1'b0;
            end
        end
        digit_out = res[sradd_pkg::DIG_W-1:0];
        bad_digit = (digit_a >= ctrl.radix) || (digit_b >= ctrl.radix);
    end

endmodule

### rtl/core/signed_radix_digit_adder_top.sv
`timescale 1ns / 1ps

// Sign-magnitude adder in a radix of 2 to 36 (register radix, reset 17; other values
// clamp). Operand digit pairs enter most significant first, one transaction per cycle
// while busy is low; up to 32 pairs are stored, more are dropped and flagged. The pair
// with last_digit set starts the computation and raises busy. A digit-serial pass then
// walks the stored pairs least significant first through one digit ALU (one operand
// memory read per cycle), followed by an emit pass that reads the result memory most
// significant first; a leading carry digit is shown before the stored digits. Results
// appear on result for one cycle each, marked by result_strobe; the receiver cannot
// stall them. Any error gives a single result with error_code set, right after the
// digit-serial pass.
// busy falls in the cycle the final result is shown. Write the radix only while idle.
module signed_radix_digit_adder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sradd_pkg::in_item_t             in_item,
    input  logic                            cfg_we,
    input  logic [sradd_pkg::DIG_W-1:0]     cfg_wdata,
    output logic                            result_strobe,
    output sradd_pkg::out_item_t            result
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        ORD_EQUAL,
        ORD_A,
        ORD_B
    } order_t;

    localparam int DW = sradd_pkg::DIG_W;
    localparam int AW = sradd_pkg::ADDR_W;
    localparam int CW = sradd_pkg::CNT_W;

    state_t               state_reg, state_next;
    order_t               order_reg, order_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [1:0]           sign_reg, sign_next;
    logic [1:0]           err_reg, err_next;
    logic [DW-1:0]        radix_reg, radix_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 issue_reg, issue_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 carry_reg, carry_next;
    sradd_pkg::out_item_t out_reg, out_next;
    logic                 strobe_reg, strobe_next;

    logic [DW-1:0]        eff_radix;
    logic                 accept;
    logic                 room;
    logic                 in_bad;
    logic                 same_sign;
    logic                 neg;
    logic [AW-1:0]        last_idx;
    logic                 last_pos;
    logic [1:0]           err_all;

    logic                 op_we;
    logic [2*DW-1:0]      op_wdata;
    logic [2*DW-1:0]      op_rdata;
    logic                 res_we;
    logic [DW-1:0]        res_rdata;

    sradd_pkg::alu_ctrl_t alu_ctrl;
    logic [DW-1:0]        alu_digit;
    logic                 alu_carry;
    logic                 alu_bad;

    // Clamped radix and per-number decisions
    always_comb
    begin
        if (radix_reg < sradd_pkg::RADIX_MIN)
        begin
            eff_radix = sradd_pkg::RADIX_MIN;
        end
        else if (radix_reg > sradd_pkg::RADIX_MAX)
        begin
            eff_radix = sradd_pkg::RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    assign accept    = start && (state_reg == ST_LOAD);
    assign room      = count_reg < CW'(sradd_pkg::MAX_DIGITS);
    assign in_bad    = (in_item.digit_a >= eff_radix) || (in_item.digit_b >= eff_radix);
    assign same_sign = sign_reg[0] == sign_reg[1];
    assign last_idx  = AW'(count_reg - CW'(1));
    assign last_pos  = rd_idx_reg == last_idx;
    assign err_all   = {err_reg[1], err_reg[0] | alu_bad};

    always_comb
    begin
        if (same_sign)
        begin
            neg = sign_reg[0];
        end
        else if (order_reg == ORD_B)
        begin
            neg = sign_reg[1];
        end
        else if (order_reg == ORD_A)
        begin
            neg = sign_reg[0];
        end
        else
        begin
            neg = 1'b0;
        end
    end

    // Operand store: both digits of a position in one word
    assign op_we    = accept && room;
    assign op_wdata = {in_item.digit_a, in_item.digit_b};

    sradd_ram #(
        .WIDTH (2 * DW),
        .DEPTH (sradd_pkg::MAX_DIGITS)
    ) u_op_ram (
        .clk   (clk),
        .we    (op_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (op_wdata),
        .raddr (idx_reg),
        .rdata (op_rdata)
    );

    // Digit ALU on the pair read back
    assign alu_ctrl.sub   = !same_sign;
    assign alu_ctrl.swap  = order_reg == ORD_B;
    assign alu_ctrl.radix = eff_radix;

    sradd_digit_alu u_alu (
        .ctrl      (alu_ctrl),
        .digit_a   (op_rdata[2*DW-1:DW]),
        .digit_b   (op_rdata[DW-1:0]),
        .carry_in  (carry_reg),
        .digit_out (alu_digit),
        .carry_out (alu_carry),
        .bad_digit (alu_bad)
    );

    // Result digits, same position as the operands
    assign res_we = (state_reg == ST_COMPUTE) && rd_vld_reg;

    sradd_ram #(
        .WIDTH (DW),
        .DEPTH (sradd_pkg::MAX_DIGITS)
    ) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (rd_idx_reg),
        .wdata (alu_digit),
        .raddr (idx_reg),
        .rdata (res_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        order_next  = order_reg;
        count_next  = count_reg;
        sign_next   = sign_reg;
        err_next    = err_reg;
        radix_next  = cfg_we ? cfg_wdata : radix_reg;
        idx_next    = idx_reg;
        issue_next  = issue_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = idx_reg;
        carry_next  = carry_reg;
        out_next    = out_reg;
        strobe_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg == '0)
                    begin
                        sign_next = {in_item.negative_b, in_item.negative_a};
                    end
                    if (!room)
                    begin
                        err_next[1] = 1'b1;
                    end
                    else
                    begin
                        err_next[0] = err_reg[0] | in_bad;
                        count_next  = count_reg + CW'(1);
                        if ((order_reg == ORD_EQUAL) && (in_item.digit_a != in_item.digit_b))
                        begin
                            order_next = (in_item.digit_a > in_item.digit_b) ? ORD_A : ORD_B;
                        end
                    end
                    if (in_item.last_digit)
                    begin
                        state_next = ST_COMPUTE;
                        idx_next   = room ? count_reg[AW-1:0] : AW'(sradd_pkg::MAX_DIGITS - 1);
                        issue_next = 1'b1;
                        carry_next = 1'b0;
                    end
                end
            end

            ST_COMPUTE:
            begin
                // issue reads from the least significant position down
                if (issue_reg)
                begin
                    rd_vld_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    err_next[0] = err_all[0];
                    carry_next  = alu_carry;
                    if (rd_idx_reg == '0)
                    begin
                        if (err_all != 2'b00)
                        begin
                            out_next.result_digit    = '0;
                            out_next.result_negative = 1'b0;
                            out_next.error_code      = err_all[0] ? sradd_pkg::ERR_DIGIT
                                                                  : sradd_pkg::ERR_COUNT;
                            out_next.last_result     = 1'b1;
                            strobe_next = 1'b1;
                            state_next  = ST_LOAD;
                            count_next  = '0;
                            order_next  = ORD_EQUAL;
                            sign_next   = 2'b00;
                            err_next    = 2'b00;
                        end
                        else
                        begin
                            // leading carry digit goes out first
                            if (same_sign && alu_carry)
                            begin
                                out_next.result_digit    = DW'(1);
                                out_next.result_negative = neg;
                                out_next.error_code      = sradd_pkg::ERR_NONE;
                                out_next.last_result     = 1'b0;
                                strobe_next = 1'b1;
                            end
                            state_next = ST_EMIT;
                            idx_next   = '0;
                            issue_next = 1'b1;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                // read results from the most significant position up
                if (issue_reg)
                begin
                    rd_vld_next = 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    out_next.result_digit    = res_rdata;
                    out_next.result_negative = neg;
                    out_next.error_code      = sradd_pkg::ERR_NONE;
                    out_next.last_result     = last_pos;
                    strobe_next = 1'b1;
                    if (last_pos)
                    begin
                        state_next  = ST_LOAD;
                        issue_next  = 1'b0;
                        rd_vld_next = 1'b0;
                        count_next  = '0;
                        order_next  = ORD_EQUAL;
                        sign_next   = 2'b00;
                        err_next    = 2'b00;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            order_reg  <= ORD_EQUAL;
            count_reg  <= '0;
            sign_reg   <= 2'b00;
            err_reg    <= 2'b00;
            radix_reg  <= sradd_pkg::RADIX_RESET;
            issue_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
            carry_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            order_reg  <= order_next;
            count_reg  <= count_next;
            sign_reg   <= sign_next;
            err_reg    <= err_next;
            radix_reg  <= radix_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= rd_vld_next;
            carry_reg  <= carry_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        out_reg    <= out_next;
    end

    assign busy          = state_reg != ST_LOAD;
    assign result_strobe = strobe_reg;
    assign result        = out_reg;

    // Checks
    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_result |-> busy)
        else $error("non-final result while idle");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.error_code != sradd_pkg::ERR_NONE)
        |-> result.last_result && (result.result_digit == '0))
        else $error("error result malformed");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && in_item.last_digit |=> busy)
        else $error("last pair did not start computation");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_strobe && result.last_result)
        else $error("busy dropped without final result");

endmodule

### test/signed_radix_digit_adder_top_tb.sv
`timescale 1ns / 1ps

module signed_radix_digit_adder_top_tb;

    // Which operand held the larger digit at the first differing position
    typedef enum logic [1:0] {
        ORDER_EQUAL    = 2'd0,
        ORDER_A_LARGER = 2'd1,
        ORDER_B_LARGER = 2'd2
    } mag_order_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    sradd_pkg::in_item_t in_item;
    logic cfg_we;
    logic [sradd_pkg::DIG_W-1:0] cfg_wdata;
    logic result_strobe;
    sradd_pkg::out_item_t result;

    // Mirror of the block's number state
    logic [sradd_pkg::DIG_W-1:0] radix_reg;
    logic [sradd_pkg::DIG_W-1:0] held_a [0:sradd_pkg::MAX_DIGITS-1];
    logic [sradd_pkg::DIG_W-1:0] held_b [0:sradd_pkg::MAX_DIGITS-1];
    int pair_count;
    mag_order_t order;
    logic [1:0] signs;
    logic [1:0] fault;

    sradd_pkg::out_item_t expected_digits [$];
    int mismatch_count = 0;
    bit gaps_on = 1'b1;

    // Operand digits of the number about to be sent, most significant first
    logic [sradd_pkg::DIG_W-1:0] op_a [0:39];
    logic [sradd_pkg::DIG_W-1:0] op_b [0:39];

    signed_radix_digit_adder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .in_item       (in_item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #2 clk = ~clk;

    // Radix after clamping to 2..36
    function automatic int base_in_use();
        if (radix_reg < sradd_pkg::RADIX_MIN)
            return int'(sradd_pkg::RADIX_MIN);
        if (radix_reg > sradd_pkg::RADIX_MAX)
            return int'(sradd_pkg::RADIX_MAX);
        return int'(radix_reg);
    endfunction

    function automatic void clear_number();
        pair_count = 0;
        order      = ORDER_EQUAL;
        signs      = 2'b00;
        fault      = 2'b00;
    endfunction

    // Take one accepted digit pair; on the last pair queue the result digits
    function automatic void add_digit_pair(input sradd_pkg::in_item_t it);
        int base;
        int sum_lsf [0:sradd_pkg::MAX_DIGITS];
        int len;
        int i;
        int carry;
        int s;
        int hi;
        int lo;
        int d;
        int borrow;
        logic neg;
        logic swap;
        sradd_pkg::out_item_t res;

        base = base_in_use();
        if (pair_count == 0)
            signs = {it.negative_b, it.negative_a};
        if (pair_count >= sradd_pkg::MAX_DIGITS)
        begin
            fault[1] = 1'b1;
        end
        else
        begin
            if (int'(it.digit_a) >= base || int'(it.digit_b) >= base)
                fault[0] = 1'b1;
            held_a[pair_count] = it.digit_a;
            held_b[pair_count] = it.digit_b;
            if (order == ORDER_EQUAL && it.digit_a != it.digit_b)
                order = (it.digit_a > it.digit_b) ? ORDER_A_LARGER : ORDER_B_LARGER;
            pair_count++;
        end
        if (!it.last_digit)
            return;

        // stored digits are checked again against the radix in force now
        for (i = 0; i < pair_count; i++)
            if (int'(held_a[i]) >= base || int'(held_b[i]) >= base)
                fault[0] = 1'b1;

        if (fault != 2'b00)
        begin
            res.result_digit    = '0;
            res.result_negative = 1'b0;
            res.error_code      = fault[0] ? sradd_pkg::ERR_DIGIT : sradd_pkg::ERR_COUNT;
            res.last_result     = 1'b1;
            expected_digits.push_back(res);
            clear_number();
            return;
        end

        len = 0;
        if (signs[0] == signs[1])
        begin
            // same signs: add magnitudes, keep a nonzero final carry
            neg   = signs[0];
            carry = 0;
            for (i = pair_count - 1; i >= 0; i--)
            begin
                s = int'(held_a[i]) + int'(held_b[i]) + carry;
                carry = s / base;
                sum_lsf[len] = s % base;
                len++;
            end
            if (carry != 0)
            begin
                sum_lsf[len] = carry;
                len++;
            end
        end
        else
        begin
            // different signs: larger magnitude minus smaller, zeros kept
            swap = (order == ORDER_B_LARGER);
            if (order == ORDER_B_LARGER)
                neg = signs[1];
            else if (order == ORDER_A_LARGER)
                neg = signs[0];
            else
                neg = 1'b0;
            borrow = 0;
            for (i = pair_count - 1; i >= 0; i--)
            begin
                hi = swap ? int'(held_b[i]) : int'(held_a[i]);
                lo = swap ? int'(held_a[i]) : int'(held_b[i]);
                d = hi - lo - borrow;
                borrow = 0;
                if (d < 0)
                begin
                    d += base;
                    borrow = 1;
                end
                sum_lsf[len] = d;
                len++;
            end
        end

        for (i = len - 1; i >= 0; i--)
        begin
            res.result_digit    = sradd_pkg::DIG_W'(sum_lsf[i]);
            res.result_negative = neg;
            res.error_code      = sradd_pkg::ERR_NONE;
            res.last_result     = (i == 0);
            expected_digits.push_back(res);
        end
        clear_number();
    endfunction

    // Result checker: every strobed digit against the oldest expectation
    always @(posedge clk)
    begin
        sradd_pkg::out_item_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("result with nothing expected: result_digit %0d error_code %0d",
                       result.result_digit, result.error_code);
                mismatch_count++;
            end
            else
            begin
                want = expected_digits.pop_front();
                if (result.result_digit !== want.result_digit)
                begin
                    $error("result_digit: expected %0d, got %0d",
                           want.result_digit, result.result_digit);
                    mismatch_count++;
                end
                if (result.result_negative !== want.result_negative)
                begin
                    $error("result_negative: expected %0d, got %0d",
                           want.result_negative, result.result_negative);
                    mismatch_count++;
                end
                if (result.error_code !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, result.error_code);
                    mismatch_count++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, result.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // One transaction: optional gap, then hold start until busy is low at an edge
    task automatic send_pair(input sradd_pkg::in_item_t it);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(99, 0) < 5)
        begin
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (busy);
        add_digit_pair(it);
    endtask

    // Send op_a/op_b[0..len-1]; signs only matter on the first pair
    task automatic send_number(input int len, input logic neg_a, input logic neg_b);
        sradd_pkg::in_item_t it;
        int i;
        for (i = 0; i < len; i++)
        begin
            it.digit_a    = op_a[i];
            it.digit_b    = op_b[i];
            it.negative_a = (i == 0) ? neg_a : logic'($urandom_range(1, 0));
            it.negative_b = (i == 0) ? neg_b : logic'($urandom_range(1, 0));
            it.last_digit = (i == len - 1);
            send_pair(it);
        end
    endtask

    task automatic set_pair(input int pos, input int a, input int b);
        op_a[pos] = sradd_pkg::DIG_W'(a);
        op_b[pos] = sradd_pkg::DIG_W'(b);
    endtask

    // Drop start and let every outstanding result come out
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_radix(input logic [sradd_pkg::DIG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        radix_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sign and carry cases in the reset radix
    task automatic test_signed_sums();
        set_pair(0, 16, 16);
        send_number(1, 1'b0, 1'b0);
        set_pair(0, 16, 0); set_pair(1, 16, 1);
        send_number(2, 1'b1, 1'b1);
        // two negative zeros stay negative
        set_pair(0, 0, 0);
        send_number(1, 1'b1, 1'b1);
        // equal magnitudes, opposite signs: positive zero
        set_pair(0, 5, 5); set_pair(1, 3, 3);
        send_number(2, 1'b1, 1'b0);
        // a larger and negative, leading zeros kept
        set_pair(0, 0, 0); set_pair(1, 9, 3); set_pair(2, 2, 5);
        send_number(3, 1'b1, 1'b0);
        set_pair(0, 1, 2); set_pair(1, 0, 0);
        send_number(2, 1'b0, 1'b1);
        set_pair(0, 4, 9);
        send_number(1, 1'b1, 1'b0);
    endtask

    task automatic test_bad_digits();
        set_pair(0, 63, 0); set_pair(1, 1, 2);
        send_number(2, 1'b0, 1'b1);
        // digit equal to the radix
        set_pair(0, 3, 17);
        send_number(1, 1'b1, 1'b1);
    endtask

    task automatic test_digit_overflow();
        int i;
        // longest number with a carry out: most results per number
        for (i = 0; i < sradd_pkg::MAX_DIGITS; i++)
            set_pair(i, 16, 16);
        send_number(sradd_pkg::MAX_DIGITS, 1'b0, 1'b0);
        for (i = 0; i < sradd_pkg::MAX_DIGITS + 2; i++)
            set_pair(i, $urandom_range(16, 0), $urandom_range(16, 0));
        send_number(sradd_pkg::MAX_DIGITS + 2, 1'b0, 1'b1);
        // both errors at once: bad digit wins
        op_a[2] = sradd_pkg::DIG_W'(40);
        send_number(sradd_pkg::MAX_DIGITS + 1, 1'b1, 1'b0);
    endtask

    task automatic test_radix_settings();
        write_radix(sradd_pkg::DIG_W'(2));
        set_pair(0, 1, 1); set_pair(1, 1, 0);
        send_number(2, 1'b0, 1'b0);
        write_radix(sradd_pkg::DIG_W'(36));
        set_pair(0, 35, 35); set_pair(1, 35, 0);
        send_number(2, 1'b1, 1'b1);
        // below the range clamps to 2
        write_radix(sradd_pkg::DIG_W'(0));
        set_pair(0, 1, 1);
        send_number(1, 1'b0, 1'b0);
        set_pair(0, 2, 0);
        send_number(1, 1'b0, 1'b0);
        // above the range clamps to 36
        write_radix(sradd_pkg::DIG_W'(63));
        set_pair(0, 35, 35);
        send_number(1, 1'b0, 1'b0);
        set_pair(0, 36, 0);
        send_number(1, 1'b0, 1'b0);
        write_radix(sradd_pkg::DIG_W'(1));
        set_pair(0, 1, 0);
        send_number(1, 1'b0, 1'b1);
        write_radix(sradd_pkg::DIG_W'(37));
        set_pair(0, 35, 1);
        send_number(1, 1'b1, 1'b0);
    endtask

    task automatic test_random_numbers();
        int items;
        int numbers;
        int len;
        int base;
        int sel;
        int i;
        int pos;
        items   = 0;
        numbers = 0;
        // first stretch runs back to back
        gaps_on = 1'b0;
        while (items < 236)
        begin
            if (items >= 120)
                gaps_on = 1'b1;
            if (numbers % 8 == 7)
            begin
                if ($urandom_range(3, 0) == 0)
                    write_radix(sradd_pkg::DIG_W'($urandom_range(63, 0)));
                else
                    write_radix(sradd_pkg::DIG_W'($urandom_range(36, 2)));
            end
            base = base_in_use();
            sel  = $urandom_range(99, 0);
            if (sel < 4)
                len = $urandom_range(sradd_pkg::MAX_DIGITS + 3, sradd_pkg::MAX_DIGITS + 1);
            else if (sel < 12)
                len = $urandom_range(sradd_pkg::MAX_DIGITS, 16);
            else
                len = $urandom_range(8, 1);
            for (i = 0; i < len; i++)
            begin
                op_a[i] = sradd_pkg::DIG_W'($urandom_range(base - 1, 0));
                // shared digits make long equal prefixes likely
                if ($urandom_range(2, 0) == 0)
                    op_b[i] = op_a[i];
                else
                    op_b[i] = sradd_pkg::DIG_W'($urandom_range(base - 1, 0));
            end
            if ($urandom_range(5, 0) == 0)
            begin
                op_a[0] = '0;
                op_b[0] = '0;
            end
            // occasional digit out of range, on either operand
            if ($urandom_range(15, 0) == 0)
            begin
                pos = $urandom_range(len - 1, 0);
                if ($urandom_range(1, 0) == 0)
                    op_a[pos] = sradd_pkg::DIG_W'($urandom_range(63, base));
                else
                    op_b[pos] = sradd_pkg::DIG_W'($urandom_range(63, base));
            end
            send_number(len, logic'($urandom_range(1, 0)), logic'($urandom_range(1, 0)));
            items += len;
            numbers++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        radix_reg = sradd_pkg::RADIX_RESET;
        clear_number();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_signed_sums();
        test_bad_digits();
        test_digit_overflow();
        test_radix_settings();
        test_random_numbers();

        wait_idle();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("signed_radix_digit_adder_top_tb: clean");
        else
            $display("signed_radix_digit_adder_top_tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1ms;
        $display("signed_radix_digit_adder_top_tb: errors");
        $finish;
    end

endmodule
